>>> rtl/c8ic_pkg.sv
// Shared types and constants of the CHIP-8 instruction core.
// Memory request structs and the font image; no dependencies.
package c8ic_pkg;

    // Request address before reduction: PC + 1 and I + line reach 13 bits
    localparam int PM_AW      = 13;
    localparam int FB_ROWS    = 32;
    localparam int FB_COLS    = 64;
    localparam int FB_RW      = 5;
    localparam int FONT_BYTES = 80;
    localparam int FONT_IW    = 7;

    localparam logic [11:0] START_RESET = 12'h200;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic             we;
        logic [PM_AW-1:0] addr;
        logic [7:0]       wdata;
    } t_pm_req;

    typedef struct packed {
        logic               clear;
        logic               we;
        logic [FB_RW-1:0]   waddr;
        logic [FB_COLS-1:0] wdata;
        logic [FB_RW-1:0]   raddr;
    } t_fb_req;

endpackage

>>> rtl/c8ic_prog_mem.sv
// Program byte memory: one synchronous port, address wrap, font reload sweep.
// Depends on c8ic_pkg.
module c8ic_prog_mem #(
    parameter int MEM_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  c8ic_pkg::t_pm_req i_req,
    input  logic              i_sweep,
    output logic [7:0]        o_rdata,
    output logic              o_busy
);
    import c8ic_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_rdata;
    logic          r_busy;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] mem_idx;
    logic [7:0]    sweep_byte;
    logic          in_font;

    // Reduce a request address modulo the depth: four compare-subtract steps
    function automatic logic [AW-1:0] wrap_addr(input logic [PM_AW-1:0] a);
        logic [16:0] v;
        logic [16:0] m;
        v = {4'b0, a};
        for (int k = 3; k >= 0; k--) begin
            m = 17'(MEM_BYTES) << k;
            if (v >= m) begin
                v = v - m;
            end
        end
        return v[AW-1:0];
    endfunction

    assign mem_idx    = wrap_addr(i_req.addr);
    assign in_font    = (r_cnt < AW'(FONT_BYTES));
    assign sweep_byte = in_font ? FONT_ROM[in_font ? r_cnt[FONT_IW-1:0] : '0] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_cnt] <= sweep_byte;
        end else if (i_req.we) begin
            r_mem[mem_idx] <= i_req.wdata;
        end
        r_rdata <= r_mem[mem_idx];
    end

    // Sweep every entry once after reset or on request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_sweep) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == AW'(MEM_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

>>> rtl/c8ic_frame_mem.sv
// Framebuffer row memory with per-row valid bits, so a clear blanks every row at once.
// Depends on c8ic_pkg.
module c8ic_frame_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  c8ic_pkg::t_fb_req           i_req,
    output logic [c8ic_pkg::FB_COLS-1:0] o_rdata
);
    import c8ic_pkg::*;

    logic [FB_COLS-1:0] r_mem [FB_ROWS];
    logic [FB_ROWS-1:0] r_valid;
    logic [FB_COLS-1:0] r_rdata;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    // An invalid row reads as blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

>>> rtl/chip8_instruction_core_unit.sv
// Top level of the CHIP-8 instruction core: command sequencer, registers, results.
// Depends on c8ic_pkg, c8ic_prog_mem and c8ic_frame_mem.

// One word in gives one word out. Program bytes sit in a single-port synchronous
// RAM of MEM_BYTES entries and the 64x32 display in a 32-row RAM, one row per
// address; V0..VF, I and PC are flip-flops. Words are taken one at a time. From
// acceptance to the result being ready: a write stores its byte, a row read
// reads one display row, a plain instruction fetches two bytes and executes,
// DXYN then walks the sprite lines (a line needs one program read, then a
// read-modify-write of one or two display rows, since a sprite line may spill
// into the next row), and reset waits for the sweep that reloads the font and
// zeros the program RAM one byte a cycle. The same sweep runs after i_rst_n, and
// no word is accepted while it runs; the start address register can be written
// meanwhile. The result sits in an output register, so a new word enters while
// the last result waits; 00E0 clears the display through row valid bits.
module chip8_instruction_core_unit #(
    parameter int MEM_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [4:0]  i_row,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_pc_value,
    output logic [15:0] o_opcode_value,
    output logic [11:0] o_index_value,
    output logic        o_display_changed,
    output logic [63:0] o_row_pixels
);
    import c8ic_pkg::*;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXEC  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_NO_RET  = 2'd2
    } t_status;

    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JUMP = 4'h1;
    localparam logic [3:0] OPG_SET  = 4'h6;
    localparam logic [3:0] OPG_ADD  = 4'h7;
    localparam logic [3:0] OPG_SETI = 4'hA;
    localparam logic [3:0] OPG_DRAW = 4'hD;
    localparam logic [3:0] SYS_CLS  = 4'h0;
    localparam logic [3:0] SYS_RET  = 4'hE;
    localparam logic [3:0] REG_VF   = 4'hF;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_SWEEP     = 12'b0000_0000_0010,
        S_FETCH_LO  = 12'b0000_0000_0100,
        S_EXEC      = 12'b0000_0000_1000,
        S_DRAW_Y    = 12'b0000_0001_0000,
        S_DRAW_LINE = 12'b0000_0010_0000,
        S_DRAW_BYTE = 12'b0000_0100_0000,
        S_DRAW_ROW0 = 12'b0000_1000_0000,
        S_DRAW_ROW1 = 12'b0001_0000_0000,
        S_DRAW_FIN  = 12'b0010_0000_0000,
        S_ROW_DATA  = 12'b0100_0000_0000,
        S_RESP      = 12'b1000_0000_0000
    } t_state;

    // sequencer and architectural state
    t_state             r_state, n_state;
    logic [11:0]        r_start;
    logic [11:0]        r_pc, n_pc;
    logic [11:0]        r_i, n_i;
    logic [7:0]         r_v [16];
    logic [7:0]         r_op_hi, n_op_hi;
    // result under construction
    logic [15:0]        r_opcode, n_opcode;
    t_status            r_status, n_status;
    logic               r_changed, n_changed;
    logic [63:0]        r_pix, n_pix;
    // sprite walk
    logic [7:0]         r_x, n_x;
    logic [7:0]         r_y, n_y;
    logic [3:0]         r_line, n_line;
    logic               r_hit, n_hit;
    logic [9:0]         r_row0, n_row0;
    logic [FB_COLS-1:0] r_mask0, n_mask0;
    logic [FB_COLS-1:0] r_mask1, n_mask1;
    // output register
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status;
    logic [11:0]        r_out_pc;
    logic [15:0]        r_out_opcode;
    logic [11:0]        r_out_index;
    logic               r_out_changed;
    logic [63:0]        r_out_pix;

    t_pm_req            pm_req;
    t_fb_req            fb_req;
    logic [7:0]         pm_rdata;
    logic [FB_COLS-1:0] fb_rdata;
    logic               pm_busy;
    logic               pm_sweep;
    logic               in_ready;
    logic               in_accept;
    logic               out_load;
    logic               v_we;
    logic               v_clr;
    logic [3:0]         v_waddr;
    logic [7:0]         v_wdata;
    logic [15:0]        exec_op;
    logic [11:0]        pc_next;
    logic [8:0]         line_y;
    logic [15:0]        pix_base;
    logic [127:0]       win;
    logic [9:0]         row1;

    c8ic_prog_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_prog_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pm_req),
        .i_sweep (pm_sweep),
        .o_rdata (pm_rdata),
        .o_busy  (pm_busy)
    );

    c8ic_frame_mem u_frame_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fb_req),
        .o_rdata (fb_rdata)
    );

    assign in_ready   = (r_state == S_IDLE) && !pm_busy;
    assign in_accept  = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    assign exec_op = {r_op_hi, pm_rdata};
    assign pc_next = r_pc + 12'd2;

    // Linear pixel index of the first sprite column; the 8 columns span
    // at most two display rows, laid out as one 128-bit window.
    assign line_y   = {1'b0, r_y} + {5'b0, r_line};
    assign pix_base = {1'b0, line_y, 6'b0} + {8'b0, r_x};
    assign win      = {pm_rdata, 120'b0} >> pix_base[5:0];
    assign row1     = r_row0 + 10'd1;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_i         = r_i;
        n_op_hi     = r_op_hi;
        n_opcode    = r_opcode;
        n_status    = r_status;
        n_changed   = r_changed;
        n_pix       = r_pix;
        n_x         = r_x;
        n_y         = r_y;
        n_line      = r_line;
        n_hit       = r_hit;
        n_row0      = r_row0;
        n_mask0     = r_mask0;
        n_mask1     = r_mask1;
        pm_req      = '0;
        pm_req.addr = {1'b0, r_pc};
        fb_req      = '0;
        fb_req.raddr = i_row;
        pm_sweep    = 1'b0;
        v_we        = 1'b0;
        v_clr       = 1'b0;
        v_waddr     = exec_op[11:8];
        v_wdata     = exec_op[7:0];
        out_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                // The fetch of the high opcode byte and the row read go out here
                if (in_accept) begin
                    n_status  = ST_OK;
                    n_changed = 1'b0;
                    n_pix     = '0;
                    n_opcode  = '0;
                    case (t_cmd'(i_command))
                        CMD_WRITE: begin
                            pm_req.we    = 1'b1;
                            pm_req.addr  = {1'b0, i_address};
                            pm_req.wdata = i_data;
                            n_state      = S_RESP;
                        end
                        CMD_EXEC: begin
                            n_state = S_FETCH_LO;
                        end
                        CMD_READ: begin
                            n_state = S_ROW_DATA;
                        end
                        CMD_RESET: begin
                            pm_sweep     = 1'b1;
                            v_clr        = 1'b1;
                            fb_req.clear = 1'b1;
                            n_i          = '0;
                            n_pc         = r_start;
                            n_state      = S_SWEEP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                if (!pm_busy) begin
                    n_state = S_RESP;
                end
            end

            S_FETCH_LO: begin
                n_op_hi     = pm_rdata;
                pm_req.addr = {1'b0, r_pc} + 13'd1;
                n_state     = S_EXEC;
            end

            S_EXEC: begin
                n_opcode = exec_op;
                n_state  = S_RESP;
                case (exec_op[15:12])
                    OPG_SYS: begin
                        if (exec_op[3:0] == SYS_CLS) begin
                            fb_req.clear = 1'b1;
                            n_changed    = 1'b1;
                            n_pc         = pc_next;
                        end else if (exec_op[3:0] == SYS_RET) begin
                            n_status = ST_NO_RET;
                        end
                    end
                    OPG_JUMP: begin
                        n_pc = exec_op[11:0];
                    end
                    OPG_SET: begin
                        v_we = 1'b1;
                        n_pc = pc_next;
                    end
                    OPG_ADD: begin
                        v_we    = 1'b1;
                        v_wdata = r_v[exec_op[11:8]] + exec_op[7:0];
                        n_pc    = pc_next;
                    end
                    OPG_SETI: begin
                        n_i  = exec_op[11:0];
                        n_pc = pc_next;
                    end
                    OPG_DRAW: begin
                        n_x     = r_v[exec_op[11:8]];
                        n_state = S_DRAW_Y;
                    end
                    default: begin
                        n_status = ST_UNKNOWN;
                    end
                endcase
            end

            S_DRAW_Y: begin
                n_y     = r_v[r_opcode[7:4]];
                n_line  = '0;
                n_hit   = 1'b0;
                n_state = S_DRAW_LINE;
            end

            S_DRAW_LINE: begin
                // Fetch the next sprite byte or finish
                if (r_line == r_opcode[3:0]) begin
                    n_state = S_DRAW_FIN;
                end else begin
                    pm_req.addr = {1'b0, r_i} + {9'b0, r_line};
                    n_state     = S_DRAW_BYTE;
                end
            end

            S_DRAW_BYTE: begin
                n_row0       = pix_base[15:6];
                n_mask0      = win[127:64];
                n_mask1      = win[63:0];
                fb_req.raddr = pix_base[FB_RW+5:6];
                n_state      = S_DRAW_ROW0;
            end

            S_DRAW_ROW0: begin
                // Rows past the bottom are dropped; read the spill row meanwhile
                if (r_row0 < 10'(FB_ROWS)) begin
                    fb_req.we    = 1'b1;
                    fb_req.waddr = r_row0[FB_RW-1:0];
                    fb_req.wdata = fb_rdata ^ r_mask0;
                    n_hit        = r_hit | (|(fb_rdata & r_mask0));
                end
                fb_req.raddr = row1[FB_RW-1:0];
                if ((r_mask1 != '0) && (row1 < 10'(FB_ROWS))) begin
                    n_state = S_DRAW_ROW1;
                end else begin
                    n_line  = r_line + 4'd1;
                    n_state = S_DRAW_LINE;
                end
            end

            S_DRAW_ROW1: begin
                fb_req.we    = 1'b1;
                fb_req.waddr = row1[FB_RW-1:0];
                fb_req.wdata = fb_rdata ^ r_mask1;
                n_hit        = r_hit | (|(fb_rdata & r_mask1));
                n_line       = r_line + 4'd1;
                n_state      = S_DRAW_LINE;
            end

            S_DRAW_FIN: begin
                v_we      = 1'b1;
                v_waddr   = REG_VF;
                v_wdata   = {7'b0, r_hit};
                n_changed = 1'b1;
                n_pc      = pc_next;
                n_state   = S_RESP;
            end

            S_ROW_DATA: begin
                n_pix   = fb_rdata;
                n_state = S_RESP;
            end

            S_RESP: begin
                // Hold until the output register is free or drains this cycle
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_load | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= START_RESET;
            r_pc        <= START_RESET;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_start <= i_cfg_data;
            end
        end
    end

    // General registers: cleared at once by reset and by the reset command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || v_clr) begin
            for (int k = 0; k < 16; k++) begin
                r_v[k] <= '0;
            end
        end else if (v_we) begin
            r_v[v_waddr] <= v_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_hi   <= n_op_hi;
        r_opcode  <= n_opcode;
        r_status  <= n_status;
        r_changed <= n_changed;
        r_pix     <= n_pix;
        r_x       <= n_x;
        r_y       <= n_y;
        r_line    <= n_line;
        r_hit     <= n_hit;
        r_row0    <= n_row0;
        r_mask0   <= n_mask0;
        r_mask1   <= n_mask1;
        if (out_load) begin
            r_out_status  <= r_status;
            r_out_pc      <= r_pc;
            r_out_opcode  <= r_opcode;
            r_out_index   <= r_i;
            r_out_changed <= r_changed;
            r_out_pix     <= r_pix;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_pc_value        = r_out_pc;
    assign o_opcode_value    = r_out_opcode;
    assign o_index_value     = r_out_index;
    assign o_display_changed = r_out_changed;
    assign o_row_pixels      = r_out_pix;

endmodule

>>> sim/c8ic_result_checker.sv
// Testbench codes and the result checker of the CHIP-8 instruction core.
// Watches the command, configuration and result ports, predicts each result word
// from its own copy of the core state and compares it; uses c8ic_pkg for the font.
package c8ic_tb_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EXEC  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_NO_RETURN = 2'd2
    } status_e;

    typedef enum logic [3:0] {
        GRP_SYS  = 4'h0,
        GRP_JUMP = 4'h1,
        GRP_SETV = 4'h6,
        GRP_ADDV = 4'h7,
        GRP_SETI = 4'hA,
        GRP_DRAW = 4'hD
    } group_e;

    localparam logic [3:0] SYS_CLEAR = 4'h0;
    localparam logic [3:0] SYS_RET   = 4'hE;

endpackage

module c8ic_result_checker
    import c8ic_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [4:0]  i_row,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [11:0] i_pc_value,
    input  logic [15:0] i_opcode_value,
    input  logic [11:0] i_index_value,
    input  logic        i_display_changed,
    input  logic [63:0] i_row_pixels,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] pc;
        logic [15:0] opcode;
        logic [11:0] index;
        logic        changed;
        logic [63:0] pixels;
    } core_result_t;

    logic [7:0]   prog_mem [4096];
    logic [63:0]  screen [32];
    logic [7:0]   vreg [16];
    logic [11:0]  ireg;
    logic [11:0]  pcreg;
    logic [11:0]  start_addr;
    core_result_t pending_results [$];
    core_result_t want;
    core_result_t got;

    task automatic reset_core();
        for (int a = 0; a < 4096; a++)
            prog_mem[a] = (a < c8ic_pkg::FONT_BYTES) ? c8ic_pkg::FONT_ROM[a] : 8'h00;
        for (int r = 0; r < 32; r++)
            screen[r] = '0;
        for (int v = 0; v < 16; v++)
            vreg[v] = '0;
        ireg = '0;
        pcreg = start_addr;
    endtask

    // XOR the sprite in; pixels past the last screen row are dropped
    task automatic draw_sprite(input logic [15:0] op);
        int          x;
        int          y;
        int          idx;
        logic [7:0]  bits;
        logic [63:0] mask;
        logic        hit;
        x = vreg[op[11:8]];
        y = vreg[op[7:4]];
        hit = 1'b0;
        for (int line = 0; line < op[3:0]; line++) begin
            bits = prog_mem[12'(ireg + line)];
            for (int col = 0; col < 8; col++) begin
                if (bits[7 - col]) begin
                    idx = x + col + (y + line) * 64;
                    if (idx < 2048) begin
                        mask = 64'd1 << (63 - idx % 64);
                        if ((screen[idx / 64] & mask) != 0)
                            hit = 1'b1;
                        screen[idx / 64] ^= mask;
                    end
                end
            end
        end
        vreg[15] = {7'd0, hit};
    endtask

    task automatic step_core(input logic [1:0] cmd, input logic [11:0] addr,
                             input logic [7:0] data, input logic [4:0] row,
                             output core_result_t res);
        logic [11:0] next_pc;
        logic [15:0] op;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_WRITE: prog_mem[addr] = data;
            CMD_READ:  res.pixels = screen[row];
            CMD_RESET: reset_core();
            CMD_EXEC: begin
                next_pc = pcreg + 12'd2;
                op = {prog_mem[pcreg], prog_mem[pcreg + 12'd1]};
                res.opcode = op;
                case (op[15:12])
                    GRP_SYS: begin
                        if (op[3:0] == SYS_CLEAR) begin
                            for (int r = 0; r < 32; r++)
                                screen[r] = '0;
                            res.changed = 1'b1;
                            pcreg = next_pc;
                        end else if (op[3:0] == SYS_RET) begin
                            res.status = ST_NO_RETURN;
                        end
                    end
                    GRP_JUMP: pcreg = op[11:0];
                    GRP_SETV: begin
                        vreg[op[11:8]] = op[7:0];
                        pcreg = next_pc;
                    end
                    GRP_ADDV: begin
                        vreg[op[11:8]] = vreg[op[11:8]] + op[7:0];
                        pcreg = next_pc;
                    end
                    GRP_SETI: begin
                        ireg = op[11:0];
                        pcreg = next_pc;
                    end
                    GRP_DRAW: begin
                        draw_sprite(op);
                        res.changed = 1'b1;
                        pcreg = next_pc;
                    end
                    default: res.status = ST_UNKNOWN;
                endcase
            end
        endcase
        res.pc = pcreg;
        res.index = ireg;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_addr = c8ic_pkg::START_RESET;
            reset_core();
            pending_results.delete();
        end else begin
            if (i_cfg_we)
                start_addr = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_pc_value, i_opcode_value, i_index_value,
                        i_display_changed, i_row_pixels};
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word: st=%0d pc=%h op=%h i=%h chg=%0d row=%h",
                                 got.status, got.pc, got.opcode, got.index, got.changed,
                                 got.pixels);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.pc !== want.pc ||
                        got.opcode !== want.opcode || got.index !== want.index ||
                        got.changed !== want.changed || got.pixels !== want.pixels) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch exp: st=%0d pc=%h op=%h i=%h chg=%0d row=%h",
                                     want.status, want.pc, want.opcode, want.index,
                                     want.changed, want.pixels);
                            $display("         got: st=%0d pc=%h op=%h i=%h chg=%0d row=%h",
                                     got.status, got.pc, got.opcode, got.index,
                                     got.changed, got.pixels);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_core(i_command, i_address, i_data, i_row, want);
                pending_results.push_back(want);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

>>> sim/chip8_instruction_core_unit_tb.sv
// Top of the CHIP-8 instruction core testbench: clock, reset, stimulus, verdict.
// Depends on c8ic_pkg, c8ic_tb_pkg and c8ic_result_checker (which predicts and
// compares), and on the RTL under test.
module chip8_instruction_core_unit_tb
    import c8ic_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Roughly 1050 words; the limit covers up to ~90 core resets (each a full sweep
    // of program RAM) plus worst-case sprite draws, gaps and stalls several times over.
    localparam int ITEM_TOTAL  = 1050;
    localparam int PHASES      = 5;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [11:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [11:0] i_address;
    logic [7:0]  i_data;
    logic [4:0]  i_row;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [11:0] o_pc_value;
    logic [15:0] o_opcode_value;
    logic [11:0] o_index_value;
    logic        o_display_changed;
    logic [63:0] o_row_pixels;

    int          fail_count;
    int          pending;
    int          words_sent;
    int          cycle_count;
    bit          quiet;         // no gaps and no stalls while set
    logic [11:0] start_now;     // start address last written to the core

    chip8_instruction_core_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_address        (i_address),
        .i_data           (i_data),
        .i_row            (i_row),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_pc_value       (o_pc_value),
        .o_opcode_value   (o_opcode_value),
        .o_index_value    (o_index_value),
        .o_display_changed(o_display_changed),
        .o_row_pixels     (o_row_pixels)
    );

    c8ic_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_address        (i_address),
        .i_data           (i_data),
        .i_row            (i_row),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_pc_value       (o_pc_value),
        .i_opcode_value   (o_opcode_value),
        .i_index_value    (o_index_value),
        .i_display_changed(o_display_changed),
        .i_row_pixels     (o_row_pixels),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the core hangs anywhere.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: stall in random bursts, advance freely in quiet stretches.
    initial begin : out_stall_gen
        int stall_left;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Drive one word at a falling edge and hold it until the core takes it.
    // Entered and left at a falling edge; valid stays high between back-to-back
    // words so it is never lowered and raised in the same step.
    task automatic send_word(input cmd_e cmd, input logic [11:0] addr,
                             input logic [7:0] data, input logic [4:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_address  <= addr;
        i_data     <= data;
        i_row      <= row;
        do
            @(posedge i_clk);
        while (o_in_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_byte(input logic [11:0] addr, input logic [7:0] data);
        send_word(CMD_WRITE, addr, data, 5'($urandom));
    endtask

    // Store an instruction big-endian; the second byte wraps past 0xFFF.
    task automatic put_op(input logic [11:0] addr, input logic [15:0] op);
        put_byte(addr, op[15:8]);
        put_byte(addr + 12'd1, op[7:0]);
    endtask

    task automatic run_exec();
        send_word(CMD_EXEC, 12'($urandom), 8'($urandom), 5'($urandom));
    endtask

    task automatic read_row(input logic [4:0] row);
        send_word(CMD_READ, 12'($urandom), 8'($urandom), row);
    endtask

    task automatic reset_core();
        send_word(CMD_RESET, 12'($urandom), 8'($urandom), 5'($urandom));
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic set_start(input logic [11:0] addr);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= addr;
        start_now = addr;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One instruction of a random program at base. The last slot jumps back to
    // base so the program loops; set values lean toward on-screen coordinates.
    function automatic logic [15:0] make_op(input logic [11:0] base, input logic [11:0] spr,
                                            input int count, input bit last);
        int         r;
        logic [3:0] grp;
        logic [7:0] val;
        r = $urandom_range(0, 99);
        val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
        if (last)
            return {GRP_JUMP, base};
        if (r < 25)
            return {GRP_SETV, 4'($urandom), val};
        if (r < 38)
            return {GRP_ADDV, 4'($urandom), 8'($urandom)};
        if (r < 50)
            return {GRP_SETI, spr};
        if (r < 72)
            return {GRP_DRAW, 4'($urandom), 4'($urandom), 4'($urandom)};
        if (r < 76)
            return {GRP_SYS, 8'($urandom), SYS_CLEAR};
        if (r < 81)
            return {GRP_JUMP, base + 12'(2 * $urandom_range(0, count - 1))};
        if (r < 85)
            return {GRP_SYS, 8'($urandom), SYS_RET};
        if (r < 89)
            return {GRP_SYS, 8'($urandom), 4'($urandom_range(1, 13))};
        // anything outside the supported groups
        do
            grp = 4'($urandom);
        while (grp == GRP_SYS || grp == GRP_JUMP || grp == GRP_SETV ||
               grp == GRP_ADDV || grp == GRP_SETI || grp == GRP_DRAW);
        return {grp, 12'($urandom)};
    endfunction

    // Reset the core, load sprite data and a looping program at the start
    // address, then step through it with row reads and stray writes mixed in.
    task automatic run_program();
        int          count;
        int          steps;
        int          pick;
        logic [11:0] spr;
        logic [11:0] base;
        quiet = ($urandom_range(0, 3) == 0);
        base = start_now;
        reset_core();
        case ($urandom_range(0, 2))
            0:       spr = 12'($urandom_range(0, 75));          // font glyphs
            1:       spr = 12'($urandom_range(12'hFF4, 12'hFFF)); // wraps to 0
            default: spr = 12'($urandom);
        endcase
        if (spr >= 12'd80) begin
            for (int i = 0; i < $urandom_range(2, 8); i++)
                put_byte(spr + 12'(i), 8'($urandom));
        end
        count = $urandom_range(3, 12);
        for (int i = 0; i < count; i++)
            put_op(base + 12'(2 * i), make_op(base, spr, count, i == count - 1));
        steps = $urandom_range(count, 2 * count + 2);
        for (int i = 0; i < steps; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                read_row(5'($urandom));
            else if (pick == 3)
                put_byte(12'($urandom), 8'($urandom));
            else
                run_exec();
        end
        read_row(5'($urandom));
        read_row(5'($urandom));
    endtask

    initial begin : stimulus
        logic [11:0] phase_start [PHASES];
        phase_start = '{12'h200, 12'h000, 12'hFFF, 12'($urandom), 12'h200};
        words_sent = 0;
        quiet = 1'b0;
        start_now = c8ic_pkg::START_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_WRITE;
        i_address = '0;
        i_data = '0;
        i_row = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the default start address 0x200.
        read_row(5'd31);
        run_exec();                        // zero word at 0x200 clears the screen
        put_op(12'h202, {GRP_SETV, 4'hE, 8'hFF});
        run_exec();
        put_op(12'h204, {GRP_DRAW, 4'hE, 4'hE, 4'd5});
        run_exec();                        // sprite fully below the screen: skipped
        put_op(12'h206, {GRP_ADDV, 4'hE, 8'h01});
        run_exec();                        // VE wraps to zero
        put_op(12'h208, {GRP_DRAW, 4'hE, 4'hE, 4'd5});
        run_exec();                        // glyph 0 at the top-left corner
        read_row(5'd0);
        put_op(12'h20A, {GRP_DRAW, 4'hE, 4'hE, 4'd5});
        run_exec();                        // same glyph again: collision, erased
        put_op(12'h20C, {GRP_DRAW, 4'hE, 4'hE, 4'd0});
        run_exec();                        // empty sprite still clears VF
        put_op(12'h20E, {GRP_SYS, 8'h0E, 4'h3});
        run_exec();                        // other zero-group word: PC holds
        reset_core();
        put_op(12'h200, {GRP_SYS, 8'h0E, SYS_RET});
        run_exec();                        // return with nothing pushed
        put_byte(12'h200, 8'hF0);
        run_exec();                        // unknown group

        // Random programs, one start address per phase.
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                set_start(phase_start[p]);
            end
            while (words_sent < (p + 1) * ITEM_TOTAL / PHASES)
                run_program();
        end

        wait_idle();
        quiet = 1'b1;
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/c8ic_pkg.sv
rtl/c8ic_prog_mem.sv
rtl/c8ic_frame_mem.sv
rtl/chip8_instruction_core_unit.sv
sim/c8ic_result_checker.sv
sim/chip8_instruction_core_unit_tb.sv
